@@ rtl/core/mf3_pkg.sv @@
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int PIX_W            = 8;
    localparam int WIN_N            = 9;
    localparam int FW_W             = 11;
    localparam int FH_W             = 12;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 12;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int Q_DEPTH_DEF      = 4;

    localparam logic [FW_W-1:0] DEF_FRAME_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0] DEF_FRAME_HEIGHT = FH_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [2:0][PIX_W-1:0] t_tri;

    // Nine neighborhood values after edge replication, row major, plus the end of frame flag.
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] pix;
        logic                        last;
    } t_win_item;

endpackage

@@ rtl/core/median_3x3_replicate.sv @@
`timescale 1ns / 1ps

// 3x3 median filter with edge replication over 8-bit grey pixels in raster order.
// The slave stream carries one item per transaction: tdata holds the pixel and
// tuser the kind, where a flush tick moves the raster on like a pixel of value zero.
// The master stream carries one result per transaction: tdata holds the median and
// tlast marks the final result of a frame. Results trail the input by one row plus
// one pixel, so the host sends frame_width + 1 flush ticks after the last pixel.
// The block takes one item per cycle while the queue has room. A window passes from
// stage one through the queue and the sort registers to the output register; the line
// store is read as an item is taken and written back from stage one.
// A four-entry queue parts the window front end from the sort pipeline, so the
// input keeps flowing while a result waits; when the receiver stalls long enough
// the queue fills and s_axis_tready falls.
// The user must write frame geometry through the configuration port only while idle;
// the block does not enforce it. Reset sets the geometry to 640 by 480, clears the
// counters, window and queue, and leaves the line stores as they are; no clearing pass.
module median_3x3_replicate #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
    parameter int Q_DEPTH   = mf3_pkg::Q_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mf3_pkg::PIX_W-1:0]         s_axis_tdata,   // [7:0] pixel
    input  logic                              s_axis_tuser,   // [0] kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mf3_pkg::PIX_W-1:0]         m_axis_tdata,   // [7:0] median
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int QCW = $clog2(Q_DEPTH+1);

    logic [mf3_pkg::FW_W-1:0] r_frame_width;
    logic [mf3_pkg::FH_W-1:0] r_frame_height;

    logic               push;
    mf3_pkg::t_win_item push_item;
    logic               pop;
    mf3_pkg::t_win_item head_item;
    logic               q_empty;
    logic [QCW-1:0]     q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3_pkg::DEF_FRAME_WIDTH;
            r_frame_height <= mf3_pkg::DEF_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mf3_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[mf3_pkg::FW_W-1:0];
                end
                mf3_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[mf3_pkg::FH_W-1:0];
                end
            endcase
        end
    end

    mf3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .Q_DEPTH   (Q_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_kind         (s_axis_tuser),
        .i_pixel        (s_axis_tdata),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_push_item    (push_item)
    );

    mf3_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_item      (head_item),
        .o_empty     (q_empty),
        .o_count     (q_count)
    );

    mf3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (head_item),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_median (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

@@ rtl/core/mf3_front.sv @@
`timescale 1ns / 1ps

module mf3_front #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
    parameter int Q_DEPTH   = mf3_pkg::Q_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mf3_pkg::FW_W-1:0]      i_frame_width,
    input  logic [mf3_pkg::FH_W-1:0]      i_frame_height,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [mf3_pkg::PIX_W-1:0]     i_pixel,
    input  logic [$clog2(Q_DEPTH+1)-1:0]  i_q_count,
    output logic                          o_push,
    output mf3_pkg::t_win_item            o_push_item
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = (CW + 1 > mf3_pkg::FW_W) ? CW + 1 : mf3_pkg::FW_W;
    localparam int QCW  = $clog2(Q_DEPTH+1);
    localparam int PW   = mf3_pkg::PIX_W;
    localparam int FH_W = mf3_pkg::FH_W;

    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_LATER  = 2'd2;

    // Input side position and output side position.
    logic [CW-1:0]   r_in_col, n_in_col;
    logic [1:0]      r_row_ph, n_row_ph;
    logic [CW-1:0]   r_out_col, n_out_col;
    logic [FH_W-1:0] r_out_row, n_out_row;

    // Stage one: the item whose line store read is in flight.
    logic            r_s1_valid;
    logic            r_s1_emit;
    logic            r_s1_byp;
    logic [CW-1:0]   r_s1_col;
    logic [PW-1:0]   r_s1_v;
    logic [3:0]      r_s1_edge;
    logic            r_s1_last;
    logic [2*PW-1:0] r_byp_data;

    // Line stores kept as one entry per column: upper byte one row up, lower byte two rows up.
    logic [2*PW-1:0] mem_lines [MAX_WIDTH];
    logic [2*PW-1:0] r_rd;

    logic [mf3_pkg::WIN_N-1:0][PW-1:0] r_win, n_win;

    logic [WW-1:0]   w_ext;
    logic [CW-1:0]   wl;
    logic [FH_W-1:0] h_ext;
    logic [FH_W-1:0] hl;
    logic [CW-1:0]   col;
    logic [CW-1:0]   oc;
    logic            emit;
    logic            col_end;
    logic            at_top, at_bottom, at_left, at_right, last;
    logic            accept;
    logic            byp;
    logic [PW-1:0]   v;
    logic [2*PW-1:0] lines;
    logic [2*PW-1:0] wr_data;
    logic [QCW:0]    q_used;

    always_comb begin
        w_ext = WW'(i_frame_width);
        if (w_ext < WW'(2)) begin
            w_ext = WW'(2);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_ext = WW'(MAX_WIDTH);
        end
        wl = CW'(w_ext - WW'(1));

        h_ext = i_frame_height;
        if (h_ext < FH_W'(2)) begin
            h_ext = FH_W'(2);
        end
        hl = h_ext - FH_W'(1);
    end

    assign col       = (r_in_col > wl) ? wl : r_in_col;
    assign oc        = (r_out_col > wl) ? wl : r_out_col;
    assign col_end   = (col == wl);
    assign emit      = (r_row_ph == ROW_LATER) || ((r_row_ph == ROW_SECOND) && (col != '0));
    assign at_top    = (r_out_row == '0);
    assign at_bottom = (r_out_row >= hl);
    assign at_left   = (oc == '0);
    assign at_right  = (oc == wl);
    assign last      = at_bottom && at_right;
    assign v         = (i_kind == mf3_pkg::KIND_FLUSH) ? '0 : i_pixel;

    assign q_used  = (QCW+1)'(i_q_count) + (QCW+1)'(r_s1_valid && r_s1_emit);
    assign o_ready = (q_used < (QCW+1)'(Q_DEPTH));
    assign accept  = i_valid && o_ready;
    assign byp     = r_s1_valid && (r_s1_col == col);

    always_comb begin
        n_in_col  = r_in_col;
        n_row_ph  = r_row_ph;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept) begin
            if (col_end) begin
                n_in_col = '0;
                if (r_row_ph != ROW_LATER) begin
                    n_row_ph = r_row_ph + 2'd1;
                end
            end else begin
                n_in_col = col + CW'(1);
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_row_ph  = ROW_FIRST;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (at_right) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + FH_W'(1);
                end else begin
                    n_out_col = oc + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_row_ph   <= ROW_FIRST;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_row_ph   <= n_row_ph;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= accept;
            r_win      <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= emit;
            r_s1_byp   <= byp;
            r_s1_col   <= col;
            r_s1_v     <= v;
            r_s1_edge  <= {at_top, at_bottom, at_left, at_right};
            r_s1_last  <= last;
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem_lines[col];
        end
        if (r_s1_valid) begin
            mem_lines[r_s1_col] <= wr_data;
        end
    end

    // The previous item wrote this column in the cycle of the read, so its data is forwarded.
    assign lines   = r_s1_byp ? r_byp_data : r_rd;
    assign wr_data = {r_s1_v, lines[2*PW-1:PW]};

    always_comb begin
        n_win = r_win;
        if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r*3]   = r_win[r*3+1];
                n_win[r*3+1] = r_win[r*3+2];
            end
            n_win[2] = lines[PW-1:0];
            n_win[5] = lines[2*PW-1:PW];
            n_win[8] = r_s1_v;
        end
    end

    always_comb begin
        int sr;
        int sc;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                sr = r;
                sc = c;
                if ((r == 0) && r_s1_edge[3]) sr = 1;
                if ((r == 2) && r_s1_edge[2]) sr = 1;
                if ((c == 0) && r_s1_edge[1]) sc = 1;
                if ((c == 2) && r_s1_edge[0]) sc = 1;
                o_push_item.pix[r*3+c] = n_win[sr*3+sc];
            end
        end
        o_push_item.last = r_s1_last;
    end

    assign o_push = r_s1_valid && r_s1_emit;

endmodule

@@ rtl/core/mf3_queue.sv @@
`timescale 1ns / 1ps

module mf3_queue #(
    parameter int DEPTH = mf3_pkg::Q_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mf3_pkg::t_win_item          i_push_item,
    input  logic                        i_pop,
    output mf3_pkg::t_win_item          o_item,
    output logic                        o_empty,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);

    mf3_pkg::t_win_item r_slots [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_item  = r_slots[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != NW'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + NW'(1)))
        else $error("queue count did not follow a lone write");

endmodule

@@ rtl/core/mf3_back.sv @@
`timescale 1ns / 1ps

module mf3_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mf3_pkg::t_win_item         i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mf3_pkg::PIX_W-1:0]  o_median,
    output logic                       o_last
);

    localparam int PW = mf3_pkg::PIX_W;

    function automatic mf3_pkg::t_tri sort3(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                            input logic [PW-1:0] c);
        logic [PW-1:0] lo1, hi1, t;
        mf3_pkg::t_tri s;
        lo1  = (a < b) ? a : b;
        hi1  = (a < b) ? b : a;
        s[0] = (lo1 < c) ? lo1 : c;
        t    = (lo1 < c) ? c : lo1;
        s[1] = (t < hi1) ? t : hi1;
        s[2] = (t < hi1) ? hi1 : t;
        return s;
    endfunction

    logic                  en;
    logic                  r_b1_valid;
    mf3_pkg::t_tri [2:0]   r_b1_rows;
    logic                  r_b1_last;
    logic                  r_b2_valid;
    mf3_pkg::t_tri         r_b2_cand;
    logic                  r_b2_last;
    logic                  r_out_valid;
    logic [PW-1:0]         r_out_med;
    logic                  r_out_last;

    mf3_pkg::t_tri         lows, mids, highs;
    mf3_pkg::t_tri         s_lo, s_mid, s_hi, s_fin;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            lows[r]  = r_b1_rows[r][0];
            mids[r]  = r_b1_rows[r][1];
            highs[r] = r_b1_rows[r][2];
        end
        s_lo  = sort3(lows[0], lows[1], lows[2]);
        s_mid = sort3(mids[0], mids[1], mids[2]);
        s_hi  = sort3(highs[0], highs[1], highs[2]);
        s_fin = sort3(r_b2_cand[0], r_b2_cand[1], r_b2_cand[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= !i_empty;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_b1_rows[r] <= sort3(i_item.pix[r*3], i_item.pix[r*3+1], i_item.pix[r*3+2]);
            end
            r_b1_last    <= i_item.last;
            // Largest of the row minima, median of the row medians, smallest of the row maxima.
            r_b2_cand[0] <= s_lo[2];
            r_b2_cand[1] <= s_mid[1];
            r_b2_cand[2] <= s_hi[0];
            r_b2_last    <= r_b1_last;
            r_out_med    <= s_fin[1];
            r_out_last   <= r_b2_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_median = r_out_med;
    assign o_last   = r_out_last;

endmodule

@@ tb/sv/median_3x3_replicate_chk.sv @@
`timescale 1ns / 1ps

module median_3x3_replicate_chk #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [mf3_pkg::PIX_W-1:0]      i_s_tdata,   // [7:0] pixel
    input  logic                           i_s_tuser,   // [0] kind
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mf3_pkg::PIX_W-1:0]      i_m_tdata,   // [7:0] median
    input  logic                           i_m_tlast,
    input  logic                           i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    import mf3_pkg::*;

    typedef struct packed {
        logic              last;
        logic [PIX_W-1:0]  median;
    } t_median_out;

    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    logic [PIX_W-1:0]  row_above     [MAX_WIDTH];
    logic [PIX_W-1:0]  row_two_above [MAX_WIDTH];
    logic [PIX_W-1:0]  win           [WIN_N];
    int                in_col;
    int                in_row;
    int                out_col;
    int                out_row;
    t_median_out       medians_due [$];
    int                fails = 0;
    int                checked = 0;

    function automatic logic [PIX_W-1:0] middle_value(input logic [WIN_N-1:0][PIX_W-1:0] vals);
        logic [PIX_W-1:0] t;
        for (int i = 0; i < WIN_N - 1; i++) begin
            for (int j = 0; j < WIN_N - 1 - i; j++) begin
                if (vals[j] > vals[j+1]) begin
                    t         = vals[j];
                    vals[j]   = vals[j+1];
                    vals[j+1] = t;
                end
            end
        end
        return vals[4];
    endfunction

    task automatic take_item(input logic kind, input logic [PIX_W-1:0] pix);
        int                           w;
        int                           h;
        int                           col;
        int                           oc;
        int                           sr;
        int                           sc;
        logic [PIX_W-1:0]             v;
        logic [PIX_W-1:0]             up1;
        logic [PIX_W-1:0]             up2;
        logic                         emit;
        logic                         at_top;
        logic                         at_bottom;
        logic                         at_left;
        logic                         at_right;
        logic [WIN_N-1:0][PIX_W-1:0]  hood;
        t_median_out                  res;
        w = int'(width_reg);
        if (w < 2) begin
            w = 2;
        end else if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        h = int'(height_reg);
        if (h < 2) begin
            h = 2;
        end
        v    = (kind == KIND_FLUSH) ? '0 : pix;
        col  = (in_col < w) ? in_col : w - 1;
        up1  = row_above[col];
        up2  = row_two_above[col];
        emit = (in_row >= 2) || (in_row == 1 && col >= 1);
        row_two_above[col] = up1;
        row_above[col]     = v;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = v;
        if (col + 1 >= w) begin
            in_col = 0;
            if (in_row < 16'hFFFF) begin
                in_row++;
            end
        end else begin
            in_col = col + 1;
        end
        if (emit) begin
            oc        = (out_col < w) ? out_col : w - 1;
            at_top    = (out_row == 0);
            at_bottom = (out_row >= h - 1);
            at_left   = (oc == 0);
            at_right  = (oc == w - 1);
            for (int r = 0; r < 3; r++) begin
                sr = r;
                if (r == 0 && at_top) begin
                    sr = 1;
                end
                if (r == 2 && at_bottom) begin
                    sr = 1;
                end
                for (int c = 0; c < 3; c++) begin
                    sc = c;
                    if (c == 0 && at_left) begin
                        sc = 1;
                    end
                    if (c == 2 && at_right) begin
                        sc = 1;
                    end
                    hood[r*3+c] = win[sr*3+sc];
                end
            end
            res.median = middle_value(hood);
            res.last   = at_bottom && at_right;
            medians_due.push_back(res);
            if (res.last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else if (at_right) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col = oc + 1;
            end
        end
    endtask

    task automatic note_failure(input string what, input t_median_out want);
        fails++;
        if (fails <= 10) begin
            $display("%0t: %s: expected median %0d last %0b, got median %0d last %0b",
                     $time, what, want.median, want.last, i_m_tdata, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        t_median_out want;
        if (!i_rst_n) begin
            width_reg  = DEF_FRAME_WIDTH;
            height_reg = DEF_FRAME_HEIGHT;
            foreach (row_above[k]) begin
                row_above[k]     = '0;
                row_two_above[k] = '0;
            end
            foreach (win[k]) begin
                win[k] = '0;
            end
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            medians_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (medians_due.size() == 0) begin
                    want = '0;
                    note_failure("result with nothing expected", want);
                end else begin
                    want = medians_due.pop_front();
                    checked++;
                    if (want.median !== i_m_tdata || want.last !== i_m_tlast) begin
                        note_failure("median mismatch", want);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[FW_W-1:0];
                end else if (i_cfg_idx == CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data[FH_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_item(i_s_tuser, i_s_tdata);
            end
        end
        o_fail_count <= fails;
        o_pending    <= medians_due.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/sv/median_3x3_replicate_tb.sv @@
`timescale 1ns / 1ps

module median_3x3_replicate_tb;

    import mf3_pkg::*;

    localparam int RANDOM_ITEMS = 830;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 8;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic [PIX_W-1:0]        s_axis_tdata  = '0;
    logic                    s_axis_tuser  = KIND_PIXEL;
    logic                    m_axis_tready = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    s_axis_tready;
    logic                    m_axis_tvalid;
    logic [PIX_W-1:0]        m_axis_tdata;
    logic                    m_axis_tlast;

    int fail_count;
    int pending;
    int checked;
    int src_gap_pct    = 29;
    int sink_stall_pct = 65;
    int quiet_cycles   = 0;
    int n_items        = 0;
    int n_flush        = 0;
    int n_frames       = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    median_3x3_replicate u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    median_3x3_replicate_chk u_median_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int clamp_dim(input int raw, input int upper);
        if (raw < 2) begin
            return 2;
        end
        return (raw > upper) ? upper : raw;
    endfunction

    function automatic logic [PIX_W-1:0] any_pixel();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return PIX_W'($urandom_range(255));
    endfunction

    task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        n_items++;
        if (kind == KIND_FLUSH) begin
            n_flush++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic program_geometry(input logic [CFG_DATA_W-1:0] wdata,
                                    input logic [CFG_DATA_W-1:0] hdata);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FRAME_WIDTH;
        i_cfg_data <= wdata;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FRAME_HEIGHT;
        i_cfg_data <= hdata;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_frame(input logic [CFG_DATA_W-1:0] wdata,
                             input logic [CFG_DATA_W-1:0] hdata,
                             input bit hold, output int count);
        int w;
        int h;
        program_geometry(wdata, hdata);
        w = clamp_dim(int'(wdata[FW_W-1:0]), MAX_WIDTH_DEF);
        h = clamp_dim(int'(hdata[FH_W-1:0]), 4095);
        for (int k = 0; k < w * h; k++) begin
            send_item(($urandom_range(19) == 0) ? KIND_FLUSH : KIND_PIXEL, any_pixel());
        end
        if (hold) begin
            wait_drained();
        end
        for (int k = 0; k <= w; k++) begin
            send_item(($urandom_range(4) == 0) ? KIND_PIXEL : KIND_FLUSH, any_pixel());
        end
        count = w * h + w + 1;
        n_frames++;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] wdata;
        int                    rand_items;
        int                    phase;
        int                    count;
        bit                    first;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frame, both registers below range: four corner pixels.
        program_geometry(12'd1, 12'd0);
        send_item(KIND_PIXEL, 8'hFF);
        send_item(KIND_PIXEL, 8'h00);
        send_item(KIND_PIXEL, 8'h00);
        send_item(KIND_PIXEL, 8'hFF);
        send_item(KIND_FLUSH, 8'h00);
        send_item(KIND_PIXEL, 8'hAA);
        send_item(KIND_FLUSH, 8'h55);
        n_frames++;

        // Three by three with a flush tick inside the frame and pixels in the tail.
        program_geometry(12'd3, 12'd3);
        send_item(KIND_PIXEL, 8'h00);
        send_item(KIND_PIXEL, 8'hFF);
        send_item(KIND_PIXEL, 8'h01);
        send_item(KIND_PIXEL, 8'hFE);
        send_item(KIND_FLUSH, 8'hFF);
        send_item(KIND_PIXEL, 8'hFF);
        send_item(KIND_PIXEL, 8'h00);
        send_item(KIND_PIXEL, 8'h80);
        send_item(KIND_PIXEL, 8'h7F);
        send_item(KIND_FLUSH, 8'h00);
        send_item(KIND_PIXEL, 8'hFF);
        send_item(KIND_FLUSH, 8'hFF);
        send_item(KIND_FLUSH, 8'h00);
        n_frames++;

        rand_items = 0;
        first      = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            phase = rand_items * 3 / RANDOM_ITEMS;
            if (phase == 0) begin
                src_gap_pct    = 29;
                sink_stall_pct = 65;
            end else if (phase == 1) begin
                src_gap_pct    = 65;
                sink_stall_pct = 29;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            wdata = CFG_DATA_W'($urandom_range(2, ($urandom_range(7) == 0) ? 40 : 12));
            // The upper data bit lies outside the width register.
            if (first) begin
                wdata[CFG_DATA_W-1] = 1'b1;
            end
            run_frame(wdata, CFG_DATA_W'($urandom_range(2, 8)),
                      first || ($urandom_range(5) == 0), count);
            rand_items += count;
            first = 1'b0;
        end

        wait_drained();
        repeat (SETTLE * 2) @(posedge i_clk);
        $display("Checked %0d medians over %0d frames from %0d input transactions (%0d flush ticks).",
                 checked, n_frames, n_items, n_flush);
        $display("Frames ranged from 2x2 up to 40 wide and 8 high under three stall patterns.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
